[src/tmcr_pkg.sv]
// Package: shared types and constants of the text-mode cell renderer.
`default_nettype none
package tmcr_pkg;

  localparam int FONT_WORDS   = 256;
  localparam int PALETTE_SIZE = 16;
  localparam int FONT_HALF    = FONT_WORDS / 2;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_FONT   = 2'd1;
  localparam logic [1:0] CMD_PAL    = 2'd2;
  localparam logic [1:0] CMD_RENDER = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_INDEX = 2'd1;

  localparam logic [15:0] BLINK_LIMIT_RST  = 16'd50000;
  localparam logic [3:0]  BORDER_INDEX_RST = 4'd0;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  slot;
    logic [15:0] data;
    logic [4:0]  cell_col;
    logic [3:0]  cell_row;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  pixel_x;
    logic [6:0]  pixel_y;
    logic [11:0] color0;
    logic [11:0] color1;
    logic [11:0] color2;
    logic [11:0] color3;
    logic [11:0] border_rgb;
    logic        last_row;
  } out_word_t;

  // One fetched cell, handed from the fetch stage to the row sequencer.
  typedef struct packed {
    logic [15:0] glyph0;
    logic [15:0] glyph1;
    logic [11:0] fg;
    logic [11:0] bg;
    logic [11:0] border;
    logic [4:0]  cell_col;
    logic [3:0]  cell_row;
  } cell_t;

endpackage
`default_nettype wire

[src/text_mode_cell_renderer.sv]
// Top level: text-mode character generator with font and palette stores.
//
// Input channel (in_valid/in_stall/in_data): one word per command. Tick,
// font-write and palette-write words are absorbed with no result. A render
// word starts a registered fetch from the font and palette RAMs, after which
// the cell is handed to the row sequencer.
// Output channel (out_valid/out_stall/out_data): eight words per rendered
// cell, glyph rows top to bottom, last_row set on the eighth.
// With the row sequencer idle, a render word passes the fetch registers (RAM
// reads and s1) and the sequencer's cell register before its first row is valid.
// Throughput: one row per cycle while out_stall is low; the row sequencer
// sets that rate, and the next cell is fetched while the current one is
// still being emitted.
// Configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; write only while the block is idle.
// Reset clears the blink counter and the pipeline and loads the registers' reset
// values; font and palette RAMs hold garbage until written.
// A stalled output holds its word; the input stalls once a fetched cell is
// waiting behind a busy sequencer.
`default_nettype none
module text_mode_cell_renderer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire tmcr_pkg::in_word_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output tmcr_pkg::out_word_t                     out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tmcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [15:0]                        cfg_data
);

  logic [15:0] blink_limit_r;
  logic [3:0]  border_index_r;
  logic [16:0] blink_count_r, blink_count_nxt;
  logic [16:0] count_inc;

  logic in_fire;
  logic is_render;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_blink_r;
  logic [4:0] s1_col_r;
  logic [3:0] s1_row_r;
  logic s1_take;

  logic [15:0] glyph_even, glyph_odd;
  logic [11:0] fg_pal, bg_pal, border_pal;
  logic font_we, pal_we;

  tmcr_pkg::cell_t fetched;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_limit_r  <= tmcr_pkg::BLINK_LIMIT_RST;
      border_index_r <= tmcr_pkg::BORDER_INDEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tmcr_pkg::REG_BLINK_LIMIT:  blink_limit_r  <= cfg_data;
        tmcr_pkg::REG_BORDER_INDEX: border_index_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = s1_valid_r && !s1_take;
  assign in_fire   = in_valid && !in_stall;
  assign is_render = (in_data.command == tmcr_pkg::CMD_RENDER);
  assign font_we   = in_fire && (in_data.command == tmcr_pkg::CMD_FONT);
  assign pal_we    = in_fire && (in_data.command == tmcr_pkg::CMD_PAL);

  assign count_inc = blink_count_r + 17'd1;

  always_comb begin
    blink_count_nxt = blink_count_r;
    if (in_fire && (in_data.command == tmcr_pkg::CMD_TICK)) begin
      blink_count_nxt = (count_inc > {blink_limit_r, 1'b0}) ? 17'd0 : count_inc;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire && is_render) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_count_r <= 17'd0;
      s1_valid_r    <= 1'b0;
    end else begin
      blink_count_r <= blink_count_nxt;
      s1_valid_r    <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_render) begin
      s1_blink_r <= in_data.data[7] && (blink_count_r > {1'b0, blink_limit_r});
      s1_col_r   <= in_data.cell_col;
      s1_row_r   <= in_data.cell_row;
    end
  end

  // Font split by address LSB so both glyph words come out in one read.
  tmcr_ram #(.WIDTH(16), .DEPTH(tmcr_pkg::FONT_HALF)) u_font_even (
    .clk   (clk),
    .we    (font_we && !in_data.slot[0]),
    .waddr (in_data.slot[7:1]),
    .wdata (in_data.data),
    .re    (in_fire && is_render),
    .raddr (in_data.data[6:0]),
    .rdata (glyph_even)
  );

  tmcr_ram #(.WIDTH(16), .DEPTH(tmcr_pkg::FONT_HALF)) u_font_odd (
    .clk   (clk),
    .we    (font_we && in_data.slot[0]),
    .waddr (in_data.slot[7:1]),
    .wdata (in_data.data),
    .re    (in_fire && is_render),
    .raddr (in_data.data[6:0]),
    .rdata (glyph_odd)
  );

  // Three palette copies: foreground, background and border read together.
  tmcr_ram #(.WIDTH(12), .DEPTH(tmcr_pkg::PALETTE_SIZE)) u_pal_fg (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_data.slot[3:0]),
    .wdata (in_data.data[11:0]),
    .re    (in_fire && is_render),
    .raddr (in_data.data[15:12]),
    .rdata (fg_pal)
  );

  tmcr_ram #(.WIDTH(12), .DEPTH(tmcr_pkg::PALETTE_SIZE)) u_pal_bg (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_data.slot[3:0]),
    .wdata (in_data.data[11:0]),
    .re    (in_fire && is_render),
    .raddr (in_data.data[11:8]),
    .rdata (bg_pal)
  );

  tmcr_ram #(.WIDTH(12), .DEPTH(tmcr_pkg::PALETTE_SIZE)) u_pal_border (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_data.slot[3:0]),
    .wdata (in_data.data[11:0]),
    .re    (in_fire && is_render),
    .raddr (border_index_r),
    .rdata (border_pal)
  );

  always_comb begin
    fetched.glyph0   = glyph_even;
    fetched.glyph1   = glyph_odd;
    fetched.fg       = s1_blink_r ? bg_pal : fg_pal;
    fetched.bg       = bg_pal;
    fetched.border   = border_pal;
    fetched.cell_col = s1_col_r;
    fetched.cell_row = s1_row_r;
  end

  tmcr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid_r),
    .load       (fetched),
    .load_take  (s1_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

[src/tmcr_ram.sv]
// Generic single-write, single-read RAM with registered, enabled read.
`default_nettype none
module tmcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/tmcr_seq.sv]
// Row sequencer: holds one fetched cell and emits its eight pixel rows.
`default_nettype none
module tmcr_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load_valid,
  input  wire tmcr_pkg::cell_t   load,
  output logic                   load_take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tmcr_pkg::out_word_t    out_data
);

  tmcr_pkg::cell_t cell_r;
  logic            valid_r, valid_nxt;
  logic [2:0]      row_r, row_nxt;
  logic            fire;
  logic            last;

  assign fire      = valid_r && !out_stall;
  assign last      = (row_r == 3'd7);
  assign load_take = load_valid && (!valid_r || (fire && last));

  always_comb begin
    valid_nxt = valid_r;
    row_nxt   = row_r;
    if (load_take) begin
      valid_nxt = 1'b1;
      row_nxt   = 3'd0;
    end else if (fire) begin
      if (last) begin
        valid_nxt = 1'b0;
      end
      row_nxt = row_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      row_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_take) begin
      cell_r <= load;
    end
  end

  assign out_valid = valid_r;

  always_comb begin
    out_data.pixel_x    = {cell_r.cell_col, 2'b00};
    out_data.pixel_y    = {cell_r.cell_row, row_r};
    out_data.color0     = cell_r.glyph0[{1'b1, row_r}] ? cell_r.fg : cell_r.bg;
    out_data.color1     = cell_r.glyph0[{1'b0, row_r}] ? cell_r.fg : cell_r.bg;
    out_data.color2     = cell_r.glyph1[{1'b1, row_r}] ? cell_r.fg : cell_r.bg;
    out_data.color3     = cell_r.glyph1[{1'b0, row_r}] ? cell_r.fg : cell_r.bg;
    out_data.border_rgb = cell_r.border;
    out_data.last_row   = last;
  end

endmodule
`default_nettype wire

[verif/tmcr_row_checker.sv]
// Checker: watches the renderer's channels, predicts each glyph-row word and compares.
`default_nettype none
module tmcr_row_checker
  import tmcr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire in_word_t             in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire out_word_t            out_data,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  output int                        pending,
  output int                        mismatches
);

  logic [15:0] font_mem [FONT_WORDS];
  logic [11:0] pal_mem [PALETTE_SIZE];
  logic [16:0] blink_ctr;
  logic [15:0] blink_lim;
  logic [3:0]  border_sel;
  out_word_t   expected_rows [$];
  out_word_t   want;
  int          err_count = 0;

  task automatic check_field(input string label, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, exp_val,
               act_val);
      err_count++;
    end
  endtask

  task automatic predict_cell_rows(input in_word_t w);
    logic [15:0] g0;
    logic [15:0] g1;
    logic [11:0] fg;
    logic [11:0] bg;
    out_word_t   row;
    fg = pal_mem[w.data[15:12]];
    bg = pal_mem[w.data[11:8]];
    if (w.data[7] && blink_ctr > {1'b0, blink_lim}) fg = bg;
    g0 = font_mem[{w.data[6:0], 1'b0}];
    g1 = font_mem[{w.data[6:0], 1'b1}];
    for (int r = 0; r < 8; r++) begin
      row.pixel_x    = {w.cell_col, 2'b00};
      row.pixel_y    = {w.cell_row, 3'b000} + 7'(r);
      row.color0     = g0[r + 8] ? fg : bg;
      row.color1     = g0[r] ? fg : bg;
      row.color2     = g1[r + 8] ? fg : bg;
      row.color3     = g1[r] ? fg : bg;
      row.border_rgb = pal_mem[border_sel];
      row.last_row   = (r == 7);
      expected_rows.push_back(row);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      blink_ctr = '0;
      blink_lim = BLINK_LIMIT_RST;
      border_sel = BORDER_INDEX_RST;
      expected_rows.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLINK_LIMIT:  blink_lim = cfg_data;
          REG_BORDER_INDEX: border_sel = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row word, expected none, actual 0x%0h", $time, out_data);
          err_count++;
        end else begin
          want = expected_rows.pop_front();
          check_field("pixel_x", want.pixel_x, out_data.pixel_x);
          check_field("pixel_y", want.pixel_y, out_data.pixel_y);
          check_field("color0", want.color0, out_data.color0);
          check_field("color1", want.color1, out_data.color1);
          check_field("color2", want.color2, out_data.color2);
          check_field("color3", want.color3, out_data.color3);
          check_field("border_rgb", want.border_rgb, out_data.border_rgb);
          check_field("last_row", want.last_row, out_data.last_row);
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.command)
          CMD_TICK: begin
            blink_ctr = blink_ctr + 17'd1;
            if (blink_ctr > {blink_lim, 1'b0}) blink_ctr = '0;
          end
          CMD_FONT:   font_mem[in_data.slot] = in_data.data;
          CMD_PAL:    pal_mem[in_data.slot[3:0]] = in_data.data[11:0];
          CMD_RENDER: predict_cell_rows(in_data);
          default: ;
        endcase
      end
    end
    pending <= expected_rows.size();
    mismatches <= err_count;
  end

endmodule
`default_nettype wire

[verif/text_mode_cell_renderer_test.sv]
// Testbench top: drives font, palette, tick and render words plus register writes.
`default_nettype none
module text_mode_cell_renderer_test;
  import tmcr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 60;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 250;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  int                   pending;
  int                   mismatches;

  int  cycles = 0;
  int  sent = 0;
  int  n_cells = 0;
  int  n_ticks = 0;
  int  n_font = 0;
  int  n_pal = 0;
  int  n_settings = 0;
  bit  calm_send = 1'b0;
  bit  font_ok [FONT_WORDS];
  bit  char_ready [FONT_HALF];
  int  ready_chars [$];
  int  partner_due [$];

  text_mode_cell_renderer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tmcr_row_checker rows (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .mismatches(mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[text_mode_cell_renderer] ERROR");
    $finish;
  end

  // Row receiver; one long hold-off, taken while the sender is offering
  // words, lets the block back up into its input.
  initial begin
    int  gap;
    int  taken;
    bit  calm;
    bit  held;
    taken = 0;
    calm = 1'b0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (taken % 48 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = calm ? 0 : $urandom_range(0, 5);
      if (!held && taken >= HOLD_AFTER && in_valid) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  function automatic void note_font(input logic [7:0] slot);
    int ch;
    ch = slot >> 1;
    font_ok[slot] = 1'b1;
    if (!font_ok[slot ^ 8'd1]) partner_due.push_back(slot ^ 8'd1);
    else if (!char_ready[ch]) begin
      char_ready[ch] = 1'b1;
      ready_chars.push_back(ch);
    end
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (sent % 40 == 0) calm_send = ($urandom_range(0, 2) == 0);
    gap = calm_send ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sent++;
    case (w.command)
      CMD_TICK:   n_ticks++;
      CMD_FONT: begin
        n_font++;
        note_font(w.slot);
      end
      CMD_PAL:    n_pal++;
      CMD_RENDER: n_cells++;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_word_t make_item();
    in_word_t w;
    int       pick;
    w.slot = 8'($urandom_range(0, 255));
    w.data = 16'($urandom_range(0, 65535));
    w.cell_col = 5'($urandom_range(0, 31));
    w.cell_row = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 11));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.command = CMD_RENDER;
      w.data[6:0] = 7'(ready_chars[$urandom_range(0, ready_chars.size() - 1)]);
    end else if (pick < 65) begin
      w.command = CMD_FONT;
      if (partner_due.size() > 0 && $urandom_range(0, 1) == 1)
        w.slot = 8'(partner_due.pop_front());
    end else if (pick < 75) begin
      w.command = CMD_PAL;
    end else begin
      w.command = CMD_TICK;
    end
    return w;
  endfunction

  task automatic run_phase(input logic [15:0] limit, input logic [3:0] border,
                           input bit spare_write);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [15:0]          val [3];
    int                   n;
    wait_idle();
    idx[0] = REG_BLINK_LIMIT;
    val[0] = limit;
    idx[1] = REG_BORDER_INDEX;
    val[1] = {12'($urandom_range(0, 4095)), border};
    idx[2] = $urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO;
    val[2] = 16'($urandom_range(0, 65535));
    n = spare_write ? 3 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    n_settings++;
    repeat (PHASE_ITEMS) send_word(make_item());
    in_valid <= 1'b0;
  endtask

  initial begin
    in_word_t w;
    wait (rst_n);
    @(posedge clk);

    // Palette with wrapping slot indexes, black and white at the ends.
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      w = '0;
      w.command = CMD_PAL;
      w.slot = {4'($urandom_range(0, 15)), 4'(i)};
      w.data = 16'($urandom_range(0, 65535));
      if (i == 0) w.data[11:0] = 12'h000;
      if (i == PALETTE_SIZE - 1) w.data[11:0] = 12'hFFF;
      send_word(w);
    end
    // Blank glyph, checker glyph, solid glyph.
    w = '0;
    w.command = CMD_FONT;
    w.slot = 8'd0;   w.data = 16'h0000; send_word(w);
    w.slot = 8'd1;   w.data = 16'h0000; send_word(w);
    w.slot = 8'd2;   w.data = 16'hA55A; send_word(w);
    w.slot = 8'd3;   w.data = 16'h0FF0; send_word(w);
    w.slot = 8'd254; w.data = 16'hFFFF; send_word(w);
    w.slot = 8'd255; w.data = 16'hFFFF; send_word(w);
    w = '0;
    w.command = CMD_TICK;
    send_word(w);
    w.command = CMD_RENDER;
    w.data = {4'd15, 4'd0, 1'b1, 7'd127};
    w.cell_col = 5'd31;
    w.cell_row = 4'd15;
    send_word(w);
    w.data = {4'd0, 4'd15, 1'b0, 7'd0};
    w.cell_col = 5'd0;
    w.cell_row = 4'd0;
    send_word(w);
    w.data = {4'd5, 4'd10, 1'b1, 7'd1};
    w.cell_col = 5'd12;
    w.cell_row = 4'd11;
    send_word(w);
    in_valid <= 1'b0;

    run_phase(16'd1, 4'd15, 1'b1);
    run_phase(16'd0, 4'd0, 1'b0);
    run_phase(16'hFFFF, 4'($urandom_range(0, 15)), 1'b0);
    run_phase(16'($urandom_range(2, 5)), 4'($urandom_range(0, 15)), 1'b1);
    run_phase(16'd3, 4'($urandom_range(0, 15)), 1'b0);

    wait_idle();
    $display("Rendered %0d cells with %0d ticks, %0d font and %0d palette writes,",
             n_cells, n_ticks, n_font, n_pal);
    $display("across %0d register settings plus the reset values.", n_settings);
    if (mismatches == 0) begin
      $display("[text_mode_cell_renderer] OK");
    end else begin
      $display("[text_mode_cell_renderer] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
